// ===== design/cpp_pkg.sv =====
// shared types, constants and saturation helpers for the cascade pid block
// no dependencies; imported by every module of the block
package cpp_pkg;

  // planner step, tick period and fixed loop limits, q16.16
  localparam int unsigned FILTER_STEP_Q16     = 66;
  localparam int unsigned TICK_PERIOD_Q16     = 66;
  localparam int unsigned OUTER_SUM_LIMIT_Q16 = 655360;
  localparam int unsigned OUTER_OUT_LIMIT_Q16 = 655360;
  localparam int unsigned INNER_SUM_LIMIT_Q16 = 655360;

  // radicand scale factor of eight as a shift
  localparam int unsigned RAD_SHIFT = 3;

  localparam int unsigned CFG_W  = 31;
  localparam int unsigned Q_W    = 32;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned ACC_W  = 50;

  // register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_PROFILE_ACCEL = 3'd0,
    REG_POS_KP        = 3'd1,
    REG_POS_KI        = 3'd2,
    REG_POS_KD        = 3'd3,
    REG_SPD_KP        = 3'd4,
    REG_SPD_KI        = 3'd5,
    REG_SPD_KD        = 3'd6,
    REG_DRIVE_LIMIT   = 3'd7
  } reg_idx_e;

  // register reset values
  localparam logic [CFG_W-1:0] PROFILE_ACCEL_RST = 31'd3276800;
  localparam logic [CFG_W-1:0] POS_KP_RST        = 31'd65536;
  localparam logic [CFG_W-1:0] POS_KI_RST        = 31'd0;
  localparam logic [CFG_W-1:0] POS_KD_RST        = 31'd0;
  localparam logic [CFG_W-1:0] SPD_KP_RST        = 31'd65536;
  localparam logic [CFG_W-1:0] SPD_KI_RST        = 31'd0;
  localparam logic [CFG_W-1:0] SPD_KD_RST        = 31'd0;
  localparam logic [CFG_W-1:0] DRIVE_LIMIT_RST   = 31'd1966080;

  typedef struct packed {
    logic [CFG_W-1:0] profile_accel;
    logic [CFG_W-1:0] pos_kp;
    logic [CFG_W-1:0] pos_ki;
    logic [CFG_W-1:0] pos_kd;
    logic [CFG_W-1:0] spd_kp;
    logic [CFG_W-1:0] spd_ki;
    logic [CFG_W-1:0] spd_kd;
    logic [CFG_W-1:0] drive_limit;
  } cfg_t;

  // datapath operations, one per controller step
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_RESEED,
    OP_X,
    OP_D,
    OP_Y,
    OP_D0,
    OP_DD,
    OP_RAD,
    OP_SQRT_GO,
    OP_A_FAR,
    OP_A_DIV_GO,
    OP_A_NEAR,
    OP_U_MUL,
    OP_U_SAT,
    OP_U_ZERO,
    OP_U_DIV_GO,
    OP_U_DIV_FIN,
    OP_P1,
    OP_P2,
    OP_P3,
    OP_ERR,
    OP_SUM,
    OP_M1,
    OP_M2,
    OP_M3,
    OP_OUT
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_RUN, S_D, S_Y, S_D0, S_DD, S_RAD, S_SQ, S_SQW, S_A, S_ADW, S_AN,
    S_UM, S_UC, S_UDW, S_UF, S_P1, S_P2, S_P3, S_E, S_S, S_M1, S_M2, S_M3,
    S_O, S_WR
  } ctl_state_e;

  typedef struct packed {
    op_e  op;
    logic inner;
  } cmd_t;

  typedef struct packed {
    logic run_en;
    logic far;
    logic big;
    logic dzero;
    logic div_busy;
    logic sqrt_busy;
  } stat_t;

  // saturate to the signed 32-bit range
  function automatic logic signed [Q_W-1:0] sat32_f(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[Q_W-1:0];
    end
  endfunction

  // symmetric clamp to +-lim, lim below 2^31
  function automatic logic signed [Q_W-1:0] clamp_f(input logic signed [63:0] v,
                                                    input logic [CFG_W-1:0] lim);
    logic signed [63:0] l;
    logic signed [63:0] nl;
    l  = $signed({33'b0, lim});
    nl = -l;
    if (v > l) begin
      return l[Q_W-1:0];
    end else if (v < nl) begin
      return nl[Q_W-1:0];
    end else begin
      return v[Q_W-1:0];
    end
  endfunction

endpackage

// ===== design/cpp_div.sv =====
// bit-serial signed divider, one quotient bit per cycle, truncating to zero
// depends on cpp_pkg
module cpp_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] dividend_i,
  input  logic        [31:0] divisor_i,
  output logic               busy_o,
  output logic signed [63:0] quot_o
);
  import cpp_pkg::*;

  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        neg_q;
  logic [62:0] num_q;
  logic [31:0] rem_q;
  logic [31:0] div_q;
  logic [32:0] rem_n;
  logic [32:0] rem_s;
  logic        qbit;
  logic signed [63:0] mag;

  // control
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd62;
    end else if (busy_q) begin
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // restoring step
  assign mag   = dividend_i[63] ? -dividend_i : dividend_i;
  assign rem_n = {rem_q, num_q[62]};
  assign qbit  = rem_n >= {1'b0, div_q};
  assign rem_s = qbit ? rem_n - {1'b0, div_q} : rem_n;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[63];
      num_q <= mag[62:0];
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= {num_q[61:0], qbit};
      rem_q <= rem_s[31:0];
    end
  end

  assign busy_o = busy_q;
  assign quot_o = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});

endmodule

// ===== design/cpp_sqrt.sv =====
// digit-by-digit integer square root, one root bit per cycle
// depends on cpp_pkg
module cpp_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        busy_o,
  output logic [31:0] root_o
);
  import cpp_pkg::*;

  logic        busy_q, busy_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [63:0] rad_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [35:0] rem_n;
  logic [35:0] trial;
  logic        hit;

  // control
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'd31;
    end else if (busy_q) begin
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // trial subtract of 4*root+1
  assign rem_n = {rem_q, rad_q[63:62]};
  assign trial = {2'b0, root_q, 2'b01};
  assign hit   = rem_n >= trial;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[61:0], 2'b00};
      rem_q  <= hit ? 34'(rem_n - trial) : rem_n[33:0];
      root_q <= {root_q[30:0], hit};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

// ===== design/cpp_ctrl.sv =====
// step sequencer for the planner and the two pid loops
// depends on cpp_pkg
module cpp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           out_free_i,
  input  cpp_pkg::stat_t stat_i,
  output cpp_pkg::cmd_t  cmd_o,
  output logic           in_ready_o,
  output logic           out_load_o
);
  import cpp_pkg::*;

  ctl_state_e state_q, state_d;
  logic       inner_q, inner_d;

  // next state
  always_comb begin
    state_d = state_q;
    inner_d = inner_q;
    unique case (state_q)
      S_IDLE: begin
        inner_d = 1'b0;
        if (in_valid_i) state_d = S_RUN;
      end
      S_RUN:  state_d = stat_i.run_en ? S_D : S_WR;
      S_D:    state_d = S_Y;
      S_Y:    state_d = S_D0;
      S_D0:   state_d = S_DD;
      S_DD:   state_d = S_RAD;
      S_RAD:  state_d = S_SQ;
      S_SQ:   state_d = S_SQW;
      S_SQW:  if (!stat_i.sqrt_busy) state_d = S_A;
      S_A:    state_d = stat_i.far ? S_UM : S_ADW;
      S_ADW:  if (!stat_i.div_busy) state_d = S_AN;
      S_AN:   state_d = S_UM;
      S_UM:   state_d = S_UC;
      S_UC:   state_d = (stat_i.big || stat_i.dzero) ? S_P1 : S_UDW;
      S_UDW:  if (!stat_i.div_busy) state_d = S_UF;
      S_UF:   state_d = S_P1;
      S_P1:   state_d = S_P2;
      S_P2:   state_d = S_P3;
      S_P3:   state_d = S_E;
      S_E:    state_d = S_S;
      S_S:    state_d = S_M1;
      S_M1:   state_d = S_M2;
      S_M2:   state_d = S_M3;
      S_M3:   state_d = S_O;
      S_O: begin
        if (inner_q) begin
          state_d = S_WR;
        end else begin
          inner_d = 1'b1;
          state_d = S_E;
        end
      end
      S_WR:   if (out_free_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.inner = inner_q;
    cmd_o.op    = OP_NOP;
    in_ready_o  = 1'b0;
    out_load_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      S_RUN:  cmd_o.op = stat_i.run_en ? OP_X : OP_RESEED;
      S_D:    cmd_o.op = OP_D;
      S_Y:    cmd_o.op = OP_Y;
      S_D0:   cmd_o.op = OP_D0;
      S_DD:   cmd_o.op = OP_DD;
      S_RAD:  cmd_o.op = OP_RAD;
      S_SQ:   cmd_o.op = OP_SQRT_GO;
      S_A:    cmd_o.op = stat_i.far ? OP_A_FAR : OP_A_DIV_GO;
      S_AN:   cmd_o.op = OP_A_NEAR;
      S_UM:   cmd_o.op = OP_U_MUL;
      S_UC: begin
        priority if (stat_i.big) cmd_o.op = OP_U_SAT;
        else if (stat_i.dzero)   cmd_o.op = OP_U_ZERO;
        else                     cmd_o.op = OP_U_DIV_GO;
      end
      S_UF:   cmd_o.op = OP_U_DIV_FIN;
      S_P1:   cmd_o.op = OP_P1;
      S_P2:   cmd_o.op = OP_P2;
      S_P3:   cmd_o.op = OP_P3;
      S_E:    cmd_o.op = OP_ERR;
      S_S:    cmd_o.op = OP_SUM;
      S_M1:   cmd_o.op = OP_M1;
      S_M2:   cmd_o.op = OP_M2;
      S_M3:   cmd_o.op = OP_M3;
      S_O:    cmd_o.op = OP_OUT;
      S_WR:   out_load_o = out_free_i;
      default: cmd_o.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      inner_q <= 1'b0;
    end else begin
      state_q <= state_d;
      inner_q <= inner_d;
    end
  end

endmodule

// ===== design/cpp_dp.sv =====
// datapath: shared multiplier, divider and root unit, planner and pid state
// depends on cpp_pkg, cpp_div, cpp_sqrt
module cpp_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cpp_pkg::cmd_t         cmd_i,
  input  cpp_pkg::cfg_t         cfg_i,
  input  logic signed [31:0]    target_pos_i,
  input  logic signed [31:0]    meas_pos_i,
  input  logic signed [31:0]    meas_spd_i,
  input  logic signed [31:0]    ff_torque_i,
  input  logic                  run_enable_i,
  output cpp_pkg::stat_t        stat_o,
  output logic signed [31:0]    drive_o,
  output logic signed [31:0]    plan_pos_o,
  output logic signed [31:0]    plan_spd_o
);
  import cpp_pkg::*;

  localparam logic [CFG_W-1:0] H_A  = CFG_W'(FILTER_STEP_Q16);
  localparam logic [CFG_W-1:0] T_A  = CFG_W'(TICK_PERIOD_Q16);
  localparam logic [CFG_W-1:0] OSL  = CFG_W'(OUTER_SUM_LIMIT_Q16);
  localparam logic [CFG_W-1:0] OOL  = CFG_W'(OUTER_OUT_LIMIT_Q16);
  localparam logic [CFG_W-1:0] ISL  = CFG_W'(INNER_SUM_LIMIT_Q16);

  // latched input word
  logic signed [Q_W-1:0] tgt_q, mpos_q, mspd_q, ff_q;
  logic                  en_q;

  // model state
  logic signed [Q_W-1:0] ppos_q, ppos_d, pspd_q, pspd_d;
  logic signed [Q_W-1:0] oerr_q, oerr_d, osum_q, osum_d;
  logic signed [Q_W-1:0] ierr_q, ierr_d, isum_q, isum_d;

  // work registers
  logic signed [Q_W-1:0]   x_q, x_d, y_q, y_d, a_q, a_d, u_q, u_d;
  logic        [CFG_W-1:0] d_q, d_d, d0_q, d0_d;
  logic        [63:0]      dd_q, dd_d, rad_q, rad_d;
  logic signed [Q_W-1:0]   e_q, e_d, spdref_q, spdref_d, drv_q, drv_d;
  logic signed [Q_W:0]     dlt_q, dlt_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [63:0]      prod_q;

  // multiplier
  logic        [CFG_W-1:0] mul_a;
  logic signed [Q_W:0]     mul_b;
  logic signed [64:0]      prod_full;
  logic signed [63:0]      prod_sh;

  // helpers
  logic signed [Q_W:0]     y_ext, a_ext, ay, aa;
  logic                    div_start, sqrt_start, div_busy, sqrt_busy;
  logic signed [63:0]      div_num, quot;
  logic        [31:0]      div_den, a0;
  logic        [Q_W:0]     half_diff;
  logic signed [63:0]      half_s;
  logic signed [Q_W-1:0]   tmp;
  logic signed [Q_W-1:0]   oc;
  logic        [64:0]      rad_sum;
  logic        [63:0]      t8;

  // loop selection
  logic signed [Q_W-1:0]   ref_s, fdb_s, err_old, sum_old, s_new;
  logic        [CFG_W-1:0] kp, ki, kd, slim, olim;

  assign ref_s   = cmd_i.inner ? spdref_q : ppos_q;
  assign fdb_s   = cmd_i.inner ? mspd_q : mpos_q;
  assign err_old = cmd_i.inner ? ierr_q : oerr_q;
  assign sum_old = cmd_i.inner ? isum_q : osum_q;
  assign kp      = cmd_i.inner ? cfg_i.spd_kp : cfg_i.pos_kp;
  assign ki      = cmd_i.inner ? cfg_i.spd_ki : cfg_i.pos_ki;
  assign kd      = cmd_i.inner ? cfg_i.spd_kd : cfg_i.pos_kd;
  assign slim    = cmd_i.inner ? ISL : OSL;
  assign olim    = cmd_i.inner ? cfg_i.drive_limit : OOL;

  // magnitudes and branch status
  assign y_ext = {y_q[Q_W-1], y_q};
  assign a_ext = {a_q[Q_W-1], a_q};
  assign ay    = y_q[Q_W-1] ? -y_ext : y_ext;
  assign aa    = a_q[Q_W-1] ? -a_ext : a_ext;

  assign stat_o.run_en    = en_q;
  assign stat_o.far       = ay > $signed({2'b0, d0_q});
  assign stat_o.big       = aa > $signed({2'b0, d_q});
  assign stat_o.dzero     = d_q == '0;
  assign stat_o.div_busy  = div_busy;
  assign stat_o.sqrt_busy = sqrt_busy;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_X:    begin mul_a = cfg_i.profile_accel; mul_b = (Q_W+1)'(FILTER_STEP_Q16); end
      OP_D:    begin mul_a = H_A; mul_b = (Q_W+1)'(pspd_q); end
      OP_Y:    begin mul_a = H_A; mul_b = $signed({2'b0, d_q}); end
      OP_D0:   begin mul_a = d_q; mul_b = $signed({2'b0, d_q}); end
      OP_DD:   begin mul_a = cfg_i.profile_accel; mul_b = ay; end
      OP_U_MUL: begin mul_a = cfg_i.profile_accel; mul_b = a_ext; end
      OP_P1:   begin mul_a = T_A; mul_b = (Q_W+1)'(pspd_q); end
      OP_P2:   begin mul_a = T_A; mul_b = (Q_W+1)'(u_q); end
      OP_SUM:  begin mul_a = kp; mul_b = (Q_W+1)'(e_q); end
      OP_M1:   begin mul_a = ki; mul_b = (Q_W+1)'(sum_old); end
      OP_M2:   begin mul_a = kd; mul_b = dlt_q; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod_full = $signed({1'b0, mul_a}) * mul_b;
  assign prod_sh   = prod_q >>> 16;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_full[63:0];
  end

  // divider and root units
  assign div_start  = (cmd_i.op == OP_A_DIV_GO) || (cmd_i.op == OP_U_DIV_GO);
  assign div_num    = (cmd_i.op == OP_A_DIV_GO) ? 64'($signed({y_q, 16'b0})) : prod_q;
  assign div_den    = (cmd_i.op == OP_A_DIV_GO) ? 32'(FILTER_STEP_Q16) : {1'b0, d_q};
  assign sqrt_start = cmd_i.op == OP_SQRT_GO;

  cpp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  cpp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (rad_q),
    .busy_o  (sqrt_busy),
    .root_o  (a0)
  );

  // radicand: 8*r*|y| + d*d, saturating at all ones
  assign t8      = {prod_q[63-RAD_SHIFT:0], RAD_SHIFT'(0)};
  assign rad_sum = {1'b0, t8} + {1'b0, dd_q};

  // half of the root minus d, for the far branch
  assign half_diff = {1'b0, a0} - {2'b0, d_q};
  assign half_s    = $signed({32'b0, half_diff[Q_W:1]});

  assign s_new = clamp_f(64'(sum_old) + 64'(e_q), slim);
  assign oc    = clamp_f(64'(acc_q), olim);

  // step execution
  always_comb begin
    ppos_d = ppos_q; pspd_d = pspd_q;
    oerr_d = oerr_q; osum_d = osum_q; ierr_d = ierr_q; isum_d = isum_q;
    x_d = x_q; y_d = y_q; a_d = a_q; u_d = u_q; d_d = d_q; d0_d = d0_q;
    dd_d = dd_q; rad_d = rad_q; e_d = e_q; dlt_d = dlt_q; acc_d = acc_q;
    spdref_d = spdref_q; drv_d = drv_q;
    tmp = '0;
    unique case (cmd_i.op)
      OP_RESEED: begin
        ppos_d = mpos_q;
        pspd_d = mspd_q;
        drv_d  = '0;
      end
      OP_X:   x_d = sat32_f(64'(ppos_q) - 64'(tgt_q));
      OP_D: begin
        tmp = sat32_f(prod_sh);
        d_d = tmp[CFG_W-1:0];
      end
      OP_Y:   y_d = sat32_f(64'(x_q) + prod_sh);
      OP_D0: begin
        tmp  = sat32_f(prod_sh);
        d0_d = tmp[CFG_W-1:0];
      end
      OP_DD:  dd_d = prod_q;
      OP_RAD: begin
        if (prod_q[63:64-RAD_SHIFT] != '0 || rad_sum[64]) begin
          rad_d = '1;
        end else begin
          rad_d = rad_sum[63:0];
        end
      end
      OP_A_FAR: begin
        if (y_q[Q_W-1]) a_d = sat32_f(64'(pspd_q) - half_s);
        else            a_d = sat32_f(64'(pspd_q) + half_s);
      end
      OP_A_NEAR:    a_d = sat32_f(64'(pspd_q) + quot);
      OP_U_SAT: begin
        if (a_q[Q_W-1]) u_d = $signed({1'b0, cfg_i.profile_accel});
        else            u_d = -$signed({1'b0, cfg_i.profile_accel});
      end
      OP_U_ZERO:    u_d = '0;
      OP_U_DIV_FIN: u_d = Q_W'(-quot);
      OP_P2:  ppos_d = sat32_f(64'(ppos_q) + prod_sh);
      OP_P3:  pspd_d = sat32_f(64'(pspd_q) + prod_sh);
      OP_ERR: e_d = sat32_f(64'(ref_s) - 64'(fdb_s));
      OP_SUM: begin
        dlt_d = (Q_W+1)'(e_q) - (Q_W+1)'(err_old);
        if (cmd_i.inner) begin
          ierr_d = e_q;
          isum_d = s_new;
        end else begin
          oerr_d = e_q;
          osum_d = s_new;
        end
      end
      OP_M1:  acc_d = ACC_W'(prod_sh);
      OP_M2:  acc_d = acc_q + ACC_W'(prod_sh);
      OP_M3:  acc_d = acc_q + ACC_W'(prod_sh);
      OP_OUT: begin
        if (cmd_i.inner) drv_d = clamp_f(64'(oc) + 64'(ff_q), cfg_i.drive_limit);
        else             spdref_d = sat32_f(64'(oc) + 64'(pspd_q));
      end
      default: tmp = '0;
    endcase
  end

  // planner and pid state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppos_q <= '0;
      pspd_q <= '0;
      oerr_q <= '0;
      osum_q <= '0;
      ierr_q <= '0;
      isum_q <= '0;
    end else begin
      ppos_q <= ppos_d;
      pspd_q <= pspd_d;
      oerr_q <= oerr_d;
      osum_q <= osum_d;
      ierr_q <= ierr_d;
      isum_q <= isum_d;
    end
  end

  // input word and work registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      tgt_q  <= target_pos_i;
      mpos_q <= meas_pos_i;
      mspd_q <= meas_spd_i;
      ff_q   <= ff_torque_i;
      en_q   <= run_enable_i;
    end
    x_q      <= x_d;
    y_q      <= y_d;
    a_q      <= a_d;
    u_q      <= u_d;
    d_q      <= d_d;
    d0_q     <= d0_d;
    dd_q     <= dd_d;
    rad_q    <= rad_d;
    e_q      <= e_d;
    dlt_q    <= dlt_d;
    acc_q    <= acc_d;
    spdref_q <= spdref_d;
    drv_q    <= drv_d;
  end

  assign drive_o    = drv_q;
  assign plan_pos_o = ppos_q;
  assign plan_spd_o = pspd_q;

endmodule

// ===== design/cascade_pid_with_profile.sv =====
// top level: stream ports, register file, output word register
// depends on cpp_pkg, cpp_ctrl, cpp_dp
//
// channel  | direction | handshake                      | payload
// s_axis   | in        | s_axis_tvalid / s_axis_tready  | tdata 128b, tuser 1b
// m_axis   | out       | m_axis_tvalid / m_axis_tready  | tdata 96b
// cfg      | in        | cfg_we_i                       | cfg_idx_i, cfg_data_i
//
// one word at a time; a disabled tick reseeds the planner from the measurements, zeroes
// the drive and goes to the output register; an enabled tick uses the root unit (32 steps) and
// each bit-serial division (63 steps), of which a tick needs none, one or two
// a finished word waits in the output register while the next word is taken
// reset clears planner and pid state to zero and loads register defaults
module cascade_pid_with_profile (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // target_pos, meas_pos, meas_spd, ff_torque
  input  logic [127:0]  s_axis_tdata,
  // run_enable
  input  logic [0:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // drive, plan_pos, plan_spd
  output logic [95:0]   m_axis_tdata,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [30:0]   cfg_data_i
);
  import cpp_pkg::*;

  cfg_t  cfg_q;
  cmd_t  cmd;
  stat_t stat;
  logic  out_free, out_load;
  logic  m_valid_q;
  logic [95:0] m_data_q;
  logic signed [Q_W-1:0] drive, plan_pos, plan_spd;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.profile_accel <= PROFILE_ACCEL_RST;
      cfg_q.pos_kp        <= POS_KP_RST;
      cfg_q.pos_ki        <= POS_KI_RST;
      cfg_q.pos_kd        <= POS_KD_RST;
      cfg_q.spd_kp        <= SPD_KP_RST;
      cfg_q.spd_ki        <= SPD_KI_RST;
      cfg_q.spd_kd        <= SPD_KD_RST;
      cfg_q.drive_limit   <= DRIVE_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_PROFILE_ACCEL: cfg_q.profile_accel <= cfg_data_i;
        REG_POS_KP:        cfg_q.pos_kp        <= cfg_data_i;
        REG_POS_KI:        cfg_q.pos_ki        <= cfg_data_i;
        REG_POS_KD:        cfg_q.pos_kd        <= cfg_data_i;
        REG_SPD_KP:        cfg_q.spd_kp        <= cfg_data_i;
        REG_SPD_KI:        cfg_q.spd_ki        <= cfg_data_i;
        REG_SPD_KD:        cfg_q.spd_kd        <= cfg_data_i;
        REG_DRIVE_LIMIT:   cfg_q.drive_limit   <= cfg_data_i;
        default:           cfg_q.drive_limit   <= cfg_q.drive_limit;
      endcase
    end
  end

  assign out_free = !m_valid_q || m_axis_tready;

  cpp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_free_i (out_free),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_ready_o (s_axis_tready),
    .out_load_o (out_load)
  );

  cpp_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_i        (cfg_q),
    .target_pos_i (s_axis_tdata[31:0]),
    .meas_pos_i   (s_axis_tdata[63:32]),
    .meas_spd_i   (s_axis_tdata[95:64]),
    .ff_torque_i  (s_axis_tdata[127:96]),
    .run_enable_i (s_axis_tuser[0]),
    .stat_o       (stat),
    .drive_o      (drive),
    .plan_pos_o   (plan_pos),
    .plan_spd_o   (plan_spd)
  );

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) m_data_q <= {plan_spd, plan_pos, drive};
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== sim/tb_cascade_pid_with_profile.sv =====
// testbench for the cascade pid block with planner: directed and random streams checked against a model
// depends on cpp_pkg and the cascade_pid_with_profile rtl
`timescale 1ns / 100ps

// queue of predicted output words and the compare against accepted words
class drive_scoreboard;
  logic [95:0] pending_q[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  function void note_word(logic [95:0] w);
    pending_q.push_back(w);
  endfunction

  // one line per mismatch, counted
  task report(string msg);
    $display("ERROR: %s", msg);
    errors++;
  endtask

  task check_word(logic [95:0] got);
    logic [95:0] want;
    if (pending_q.size() == 0) begin
      report($sformatf("output word %h with nothing expected", got));
      return;
    end
    want = pending_q.pop_front();
    if (got[31:0] !== want[31:0]) begin
      report($sformatf("drive got %h want %h", got[31:0], want[31:0]));
    end
    if (got[63:32] !== want[63:32]) begin
      report($sformatf("plan_pos got %h want %h", got[63:32], want[63:32]));
    end
    if (got[95:64] !== want[95:64]) begin
      report($sformatf("plan_spd got %h want %h", got[95:64], want[95:64]));
    end
  endtask
endclass

module tb_cascade_pid_with_profile;
  import cpp_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [0:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [30:0]  cfg_data_i = '0;

  drive_scoreboard sb = new();

  // model state
  logic [30:0] gain_r[8];
  longint pos_m, spd_m, oerr_m, osum_m, ierr_m, isum_m;

  bit hold_off = 1'b0;
  bit stim_done = 1'b0;
  int idle_cycles = 0;

  cascade_pid_with_profile u_top (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // q16.16 arithmetic helpers
  function automatic longint sat_q(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp_q(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // exact wide product shifted right 16, floor
  function automatic longint mul_q(longint a, longint b);
    logic signed [127:0] p;
    p = 128'(a) * 128'(b);
    return longint'(p >>> 16);
  endfunction

  function automatic longint unsigned root_u(longint unsigned v);
    longint unsigned res, one;
    res = 0;
    one = 64'd1 << 62;
    while (one > v) one >>= 2;
    while (one != 0) begin
      if (v >= res + one) begin
        v -= res + one;
        res = (res >> 1) + one;
      end else begin
        res >>= 1;
      end
      one >>= 2;
    end
    return res;
  endfunction

  // tracking differentiator step
  function automatic void advance_planner(longint aim);
    longint r, h, x2, x, d, d0, y, ya, a0, a, u, half;
    longint unsigned dd, t, rad;
    r = longint'(gain_r[REG_PROFILE_ACCEL]);
    h = longint'(FILTER_STEP_Q16);
    x2 = spd_m;
    x = sat_q(pos_m - aim);
    d = sat_q(mul_q(r, h));
    d0 = sat_q(mul_q(h, d));
    y = sat_q(x + mul_q(h, x2));
    ya = (y < 0) ? -y : y;
    dd = longint'(d) * longint'(d);
    t = longint'(r) * longint'(ya);
    if (t > 64'hFFFF_FFFF_FFFF_FFFF / 8) t = 64'hFFFF_FFFF_FFFF_FFFF;
    else t = t * 8;
    rad = (t > 64'hFFFF_FFFF_FFFF_FFFF - dd) ? 64'hFFFF_FFFF_FFFF_FFFF : t + dd;
    a0 = longint'(root_u(rad));
    if (ya > d0) begin
      half = (a0 - d) >>> 1;
      a = sat_q(y > 0 ? x2 + half : x2 - half);
    end else begin
      a = sat_q(x2 + (y * 65536) / h);
    end
    if (((a < 0) ? -a : a) > d) u = (a > 0) ? -r : r;
    else if (d == 0) u = 0;
    else u = -((r * a) / d);
    pos_m = sat_q(pos_m + mul_q(longint'(TICK_PERIOD_Q16), x2));
    spd_m = sat_q(x2 + mul_q(longint'(TICK_PERIOD_Q16), u));
  endfunction

  function automatic longint pid_step(ref longint err, ref longint sum, input longint ref_v,
                                      input longint fdb, input longint kp, input longint ki,
                                      input longint kd, input longint sum_lim,
                                      input longint out_lim);
    longint last, e, s;
    last = err;
    e = sat_q(ref_v - fdb);
    s = clamp_q(sum + e, sum_lim);
    err = e;
    sum = s;
    return clamp_q(mul_q(kp, e) + mul_q(ki, s) + mul_q(kd, e - last), out_lim);
  endfunction

  // predicted output word for one input word
  function automatic logic [95:0] predict_drive(logic [127:0] w, logic en);
    longint tgt, mp, ms, ff, lim, po, sref, so, drv;
    tgt = longint'($signed(w[31:0]));
    mp = longint'($signed(w[63:32]));
    ms = longint'($signed(w[95:64]));
    ff = longint'($signed(w[127:96]));
    drv = 0;
    if (en) begin
      lim = longint'(gain_r[REG_DRIVE_LIMIT]);
      advance_planner(tgt);
      po = pid_step(oerr_m, osum_m, pos_m, mp, longint'(gain_r[REG_POS_KP]),
                    longint'(gain_r[REG_POS_KI]), longint'(gain_r[REG_POS_KD]),
                    longint'(OUTER_SUM_LIMIT_Q16), longint'(OUTER_OUT_LIMIT_Q16));
      sref = sat_q(po + spd_m);
      so = pid_step(ierr_m, isum_m, sref, ms, longint'(gain_r[REG_SPD_KP]),
                    longint'(gain_r[REG_SPD_KI]), longint'(gain_r[REG_SPD_KD]),
                    longint'(INNER_SUM_LIMIT_Q16), lim);
      drv = clamp_q(so + ff, lim);
    end else begin
      pos_m = mp;
      spd_m = ms;
    end
    return {spd_m[31:0], pos_m[31:0], drv[31:0]};
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [30:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gain_r[idx] = val;
    @(posedge clk_i);
  endtask

  // send one word, holding valid until accepted
  task automatic send_word(logic [127:0] w, logic en);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= w;
    s_axis_tuser <= en;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_word(predict_drive(w, en));
  endtask

  task automatic drain_words();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_q(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 655360) - 327680;
      default: return $urandom_range(0, 100) - 50;
    endcase
  endfunction

  // random word: mostly modest values, sometimes full range
  function automatic logic [127:0] rand_word();
    int m;
    m = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2);
    return {rand_q(m), rand_q(m), rand_q(m), rand_q(m)};
  endfunction

  task automatic random_phase(int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 6);
      while (burst > 0 && count > 0) begin
        send_word(rand_word(), $urandom_range(0, 7) != 0);
        burst--;
        count--;
      end
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
  endtask

  // receiver stall pattern with one long hold-off
  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  // output checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    gain_r[0] = PROFILE_ACCEL_RST; gain_r[1] = POS_KP_RST;
    gain_r[2] = POS_KI_RST;        gain_r[3] = POS_KD_RST;
    gain_r[4] = SPD_KP_RST;        gain_r[5] = SPD_KI_RST;
    gain_r[6] = SPD_KD_RST;        gain_r[7] = DRIVE_LIMIT_RST;
    pos_m = 0; spd_m = 0; oerr_m = 0; osum_m = 0; ierr_m = 0; isum_m = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: defaults, field extremes, disabled ticks, zero planner band
    send_word('0, 1'b1);
    send_word({4{32'h7FFF_FFFF}}, 1'b1);
    send_word({4{32'h8000_0000}}, 1'b1);
    send_word({32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF}, 1'b1);
    send_word({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000}, 1'b0);
    send_word({32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0}, 1'b1);
    send_word({32'h0, 32'h0, 32'h0, 32'h0}, 1'b0);
    drain_words();
    write_reg(REG_PROFILE_ACCEL, '0);
    send_word('0, 1'b1);
    send_word({32'h0, 32'h0, 32'h0, 32'h0001_0000}, 1'b1);
    drain_words();
    write_reg(REG_PROFILE_ACCEL, 31'h7FFF_FFFF);
    write_reg(REG_POS_KP, 31'h7FFF_FFFF);
    write_reg(REG_POS_KI, 31'h7FFF_FFFF);
    write_reg(REG_POS_KD, 31'h7FFF_FFFF);
    write_reg(REG_SPD_KP, 31'h7FFF_FFFF);
    write_reg(REG_SPD_KI, 31'h7FFF_FFFF);
    write_reg(REG_SPD_KD, 31'h7FFF_FFFF);
    write_reg(REG_DRIVE_LIMIT, 31'h7FFF_FFFF);
    send_word({4{32'h7FFF_FFFF}}, 1'b1);
    send_word({4{32'h8000_0000}}, 1'b1);
    send_word(rand_word(), 1'b1);
    drain_words();
    write_reg(REG_DRIVE_LIMIT, '0);
    send_word(rand_word(), 1'b1);
    send_word(rand_word(), 1'b1);
    drain_words();

    // long receiver hold-off while words keep coming
    hold_off = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      random_phase(6);
    join
    drain_words();

    // random phases over several gain settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_PROFILE_ACCEL,
                (ph == 5) ? 31'h7FFF_FFFF : 31'($urandom_range(0, 6553600)));
      write_reg(REG_POS_KP, 31'($urandom_range(0, 262144)));
      write_reg(REG_POS_KI, (ph == 0) ? 31'd0 : 31'($urandom_range(0, 32768)));
      write_reg(REG_POS_KD, 31'($urandom_range(0, 131072)));
      write_reg(REG_SPD_KP, 31'($urandom_range(0, 262144)));
      write_reg(REG_SPD_KI, (ph == 0) ? 31'd0 : 31'($urandom_range(0, 32768)));
      write_reg(REG_SPD_KD, (ph == 4) ? 31'h7FFF_FFFF : 31'($urandom_range(0, 131072)));
      write_reg(REG_DRIVE_LIMIT,
                (ph == 3) ? 31'h7FFF_FFFF : 31'($urandom_range(0, 3932160)));
      random_phase(120);
      drain_words();
    end

    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
